[rtl/core/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg: shared types and codes of the postfix stack evaluator
// Token action codes, result status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DIV_CNT_W = 3;

  // token actions
  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MOD  = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVER     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER = 3'd4;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 3'd7;

  typedef struct packed {
    logic load_tok;  // capture the accepted token
    logic exec;      // check the token, do a push, start an operand read
    logic alu;       // combine operands, or check the divisor
    logic div_step;  // one restoring divide step
    logic div_wb;    // write quotient or remainder back
    logic emit;      // load the result register and close the token
  } cmd_t;

  typedef struct packed {
    logic need_read; // operator with two operands and no pending error
    logic div_go;    // divide or modulo with a nonzero divisor
    logic div_last;  // final divide step in progress
    logic out_free;  // result register can take a new request
  } sts_t;

endpackage

[rtl/core/pse_ctrl.sv]
// ----------------------------------------------------------------------------
// pse_ctrl: token sequencer of the postfix stack evaluator
// Walks one token through check, operand read, arithmetic, divide and
// result hand-off, issuing one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pse_pkg::sts_t sts_i,
  output pse_pkg::cmd_t cmd_o
);
  import pse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALU,
    S_DIV,
    S_DIVWB,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_EXEC:  state_d = sts_i.need_read ? S_ALU : S_EMIT;
      S_ALU:   state_d = sts_i.div_go ? S_DIV : S_EMIT;
      S_DIV:   if (sts_i.div_last) state_d = S_DIVWB;
      S_DIVWB: state_d = S_EMIT;
      S_EMIT:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_tok = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.alu      = (state_q == S_ALU);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.div_wb   = (state_q == S_DIVWB);
    cmd_o.emit     = (state_q == S_EMIT) && sts_i.out_free;
  end

`ifndef SYNTHESIS
  a_div_leaves_by_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && sts_i.div_last |=> (state_q == S_DIVWB))
    else $error("divide did not hand over to write-back");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_tok |=> (state_q == S_EXEC) && !in_ready_o)
    else $error("token accepted without entering execution");

  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> in_ready_o)
    else $error("controller did not return to idle after result");
`endif

endmodule

[rtl/core/pse_dp.sv]
// ----------------------------------------------------------------------------
// pse_dp: datapath of the postfix stack evaluator
// Operand stack memory with a cached top entry, entry count, sticky error,
// 8-bit ALU, restoring divider and the result register.
// ----------------------------------------------------------------------------
module pse_dp #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pse_pkg::cmd_t                  cmd_i,
  output pse_pkg::sts_t                  sts_o,
  input  logic [pse_pkg::ACT_W-1:0]      act_i,
  input  logic [pse_pkg::DIGIT_W-1:0]    digit_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pse_pkg::DATA_W-1:0]     out_value_o,
  output logic [pse_pkg::STATUS_W-1:0]   out_status_o,
  output logic                           out_last_o
);
  import pse_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);

  // token
  logic [ACT_W-1:0]   act_q;
  logic [DIGIT_W-1:0] digit_q;
  logic               last_q;

  // stack state
  logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rdata_q;
  logic [DATA_W-1:0]   top_q, top_d;
  logic [CW-1:0]       count_q, count_d;
  logic [STATUS_W-1:0] err_q, err_d;

  // divider
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [DATA_W:0]      rem_sh, rem_diff;

  // result register
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_value_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  logic [CW-1:0]       count_m2;
  logic [IW-1:0]       rd_idx;
  logic [IW-1:0]       wr_idx;
  logic                we;
  logic [DATA_W-1:0]   wdata;
  logic                is_op, is_div_op;
  logic [2*DATA_W-1:0] product;
  logic [DATA_W-1:0]   alu_res;
  logic [DATA_W-1:0]   emit_value;
  logic [STATUS_W-1:0] emit_status;

  assign count_m2  = count_q - CW'(2);
  assign rd_idx    = count_m2[IW-1:0];
  assign is_op     = (act_q == ACT_ADD) || (act_q == ACT_SUB) || (act_q == ACT_MUL) ||
                     (act_q == ACT_DIV) || (act_q == ACT_MOD);
  assign is_div_op = (act_q == ACT_DIV) || (act_q == ACT_MOD);
  assign product   = rdata_q * top_q;

  // left operand comes from memory, right operand is the cached top
  always_comb begin
    case (act_q)
      ACT_ADD: alu_res = rdata_q + top_q;
      ACT_SUB: alu_res = rdata_q - top_q;
      ACT_MUL: alu_res = product[DATA_W-1:0];
      default: alu_res = '0;
    endcase
  end

  assign rem_sh   = {rem_q, quo_q[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, top_q};

  assign sts_o.need_read = (err_q == ST_OK) && is_op && (count_q >= CW'(2));
  assign sts_o.div_go    = is_div_op && (top_q != '0);
  assign sts_o.div_last  = (div_cnt_q == DIV_LAST_STEP);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    emit_value  = (count_q == '0) ? '0 : top_q;
    emit_status = err_q;
    if (last_q && (err_q == ST_OK)) begin
      if (count_q == '0) begin
        emit_status = ST_UNDER;
      end else if (count_q > CW'(1)) begin
        emit_status = ST_LEFTOVER;
      end
    end
    if (last_q && (emit_status != ST_OK)) begin
      emit_value = '0;
    end
  end

  always_comb begin
    count_d   = count_q;
    err_d     = err_q;
    top_d     = top_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    div_cnt_d = div_cnt_q;
    we        = 1'b0;
    wr_idx    = rd_idx;
    wdata     = alu_res;

    if (cmd_i.exec && (err_q == ST_OK)) begin
      if (act_q == ACT_PUSH) begin
        if (count_q >= CW'(STACK_DEPTH)) begin
          err_d = ST_OVER;
        end else begin
          we      = 1'b1;
          wr_idx  = count_q[IW-1:0];
          wdata   = DATA_W'(digit_q);
          top_d   = DATA_W'(digit_q);
          count_d = count_q + CW'(1);
        end
      end else if (is_op && (count_q < CW'(2))) begin
        err_d = ST_UNDER;
      end
    end

    if (cmd_i.alu) begin
      if (is_div_op) begin
        if (top_q == '0) begin
          err_d = ST_DIVZERO;
        end else begin
          quo_d     = rdata_q;
          rem_d     = '0;
          div_cnt_d = '0;
        end
      end else begin
        we      = 1'b1;
        top_d   = alu_res;
        count_d = count_q - CW'(1);
      end
    end

    if (cmd_i.div_step) begin
      if (!rem_diff[DATA_W]) begin
        rem_d = rem_diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
    end

    if (cmd_i.div_wb) begin
      we      = 1'b1;
      wdata   = (act_q == ACT_DIV) ? quo_q : rem_q;
      top_d   = wdata;
      count_d = count_q - CW'(1);
    end

    // end of expression: drop the stack and the error
    if (cmd_i.emit && last_q) begin
      count_d = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[wr_idx] <= wdata;
    end
    rdata_q <= stack_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      act_q   <= act_i;
      digit_q <= digit_i;
      last_q  <= last_i;
    end
    top_q <= top_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.emit) begin
      out_value_q  <= emit_value;
      out_status_q <= emit_status;
      out_last_q   <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= ST_OK;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      err_q     <= err_d;
      div_cnt_q <= div_cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q <= ST_OVER)
    else $error("sticky error holds a non-error code");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && last_q |=> (count_q == '0) && (err_q == ST_OK))
    else $error("end of expression did not clear stack state");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (top_q != '0))
    else $error("divide step with zero divisor");
`endif

endmodule

[rtl/core/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: reverse Polish evaluator on an 8-bit stack
// Channel  | Dir | tdata (low bit up)             | tlast          | tuser
// s_axis   | in  | action[2:0], digit[6:3], 0[7]  | last token     | -
// m_axis   | out | value[7:0], status[10:8], 0    | expression end | -
//
// A push, an underflow or an ignored token goes from check straight to result;
// add, subtract, multiply or a zero divisor add one registered stack read;
// divide and modulo add 8 restoring divider steps and a write-back. A waiting
// result does not block the input: the next token runs, then holds in its last
// cycle. Reset clears only stack count, error, step count, state, result valid.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // action[2:0], digit[6:3], zero[7]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // value[7:0], status[10:8], zero[15:11]
  output logic        m_axis_tlast_o    // done_res
);
  import pse_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [DATA_W-1:0]   out_value;
  logic [STATUS_W-1:0] out_status;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .act_i        (s_axis_tdata_i[2:0]),
    .digit_i      (s_axis_tdata_i[6:3]),
    .last_i       (s_axis_tlast_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (out_value),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, out_status, out_value};

endmodule
